>>> rtl/core/drpc_pkg.sv
`timescale 1ns / 1ps
package drpc_pkg;

  localparam int POS_BITS = 16;
  localparam int CNT_BITS = 32;
  localparam int ANG_BITS = 9;
  localparam int ADDR_W   = 3;

  localparam logic [ANG_BITS-1:0] FULL_CIRCLE = 9'd360;

  localparam logic [ADDR_W-1:0] ADDR_MAX_POS = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_CAL     = 3'd4;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_MOVE   = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;
  localparam logic [1:0] ACT_ORIGIN = 2'd3;

  localparam logic [1:0] DIR_CW    = 2'd0;
  localparam logic [1:0] DIR_CCW   = 2'd1;
  localparam logic [1:0] DIR_SHORT = 2'd2;
  localparam logic [1:0] DIR_BAD   = 2'd3;

  localparam logic [2:0] KIND_REL  = 3'd0;
  localparam logic [2:0] KIND_ABS  = 3'd1;
  localparam logic [2:0] KIND_HOME = 3'd2;
  localparam logic [2:0] KIND_TURN = 3'd3;
  localparam logic [2:0] KIND_MAN  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DIR   = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NOT_CAL  = 3'd3;
  localparam logic [2:0] ST_NO_SHORT = 3'd4;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_CW   = 2'd1,
    DRV_CCW  = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV1,
    S_DIV2,
    S_MUL,
    S_APPLY
  } seq_state_t;

  function automatic logic [CNT_BITS-1:0] times_360(input logic [POS_BITS-1:0] p);
    logic [CNT_BITS-1:0] x;
    x = {{(CNT_BITS-POS_BITS){1'b0}}, p};
    return (x << 8) + (x << 6) + (x << 5) + (x << 3);
  endfunction

endpackage

>>> rtl/core/drpc_div.sv
`timescale 1ns / 1ps
module drpc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [drpc_pkg::CNT_BITS-1:0] dividend,
  input  logic [drpc_pkg::POS_BITS-1:0] divisor,
  output logic                          done,
  output logic [drpc_pkg::CNT_BITS-1:0] quotient
);
  import drpc_pkg::*;

  localparam int CW = $clog2(CNT_BITS);

  logic [POS_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_BITS-1:0] quo_r, quo_nxt;
  logic [POS_BITS-1:0] dsr_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [POS_BITS:0]   shifted;
  logic [POS_BITS+1:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[CNT_BITS-1]};
    diff     = {1'b0, shifted} - {2'b00, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[POS_BITS+1]) begin
        rem_nxt = diff[POS_BITS-1:0];
        quo_nxt = {quo_r[CNT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[POS_BITS-1:0];
        quo_nxt = {quo_r[CNT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(CNT_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/dome_rotation_position_controller.sv
`timescale 1ns / 1ps
// dome rotation position controller
// input channel (in_valid/in_ready): one item per transfer, action selects
// tick sample, move command, stop or set origin; other fields as named.
// result channel (out_valid/out_ready): exactly one result per input item,
// in order, held in an output register until taken.
// config: apb-style port, max_positions at 0x0, calibrated at 0x4; the user
// must write these only while the block is idle, which the block itself does
// not enforce; pready is tied high.
// sequence: ticks, stops, origin and most moves pass through the decide and
// apply states to a registered result; a calibrated relative move that must
// wrap the target adds a division and a multiply step, a shortest-direction
// move adds two divisions; a serial divider gives one quotient bit per cycle.
// the block takes one item at a time; in_ready is high in idle even while
// a result waits, and the finishing step waits until the output register
// is free, so a stalled receiver holds the block after at most one item.
// reset (synchronous, rst_n low) clears all counts, stops the drive, turns
// power off and sets max_positions to 1 and calibrated to 0.
module dome_rotation_position_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_action,
  input  logic                                 in_encoder_level,
  input  logic                                 in_home_sensor,
  input  logic [1:0]                           in_direction,
  input  logic [2:0]                           in_target_kind,
  input  logic signed [16:0]                   in_amount,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_cw_drive,
  output logic                                 out_ccw_drive,
  output logic                                 out_power_on,
  output logic signed [drpc_pkg::CNT_BITS-1:0] out_relative_position,
  output logic [drpc_pkg::POS_BITS-1:0]        out_absolute_position,
  output logic                                 out_absolute_valid,
  output logic                                 out_moving,
  output logic                                 out_move_done,
  output logic [2:0]                           out_command_status,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [drpc_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import drpc_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [POS_BITS-1:0] maxp_r;
  logic                cal_r;

  logic [CNT_BITS-1:0] rel_r, rel_n;
  logic [POS_BITS-1:0] abs_r, abs_n;
  logic                known_r, known_n;
  logic                prev_r, prev_n;
  drive_t              drv_r, drv_n;
  logic [2:0]          kind_r, kind_n;
  logic [CNT_BITS-1:0] tgt_r, tgt_n;
  logic                wrap_r, wrap_n;
  logic [CNT_BITS-1:0] start_r, start_n;
  logic                pwr_r, pwr_n;

  logic [1:0]  ia_action_r;
  logic        ia_enc_r;
  logic        ia_home_r;
  logic [1:0]  ia_dir_r;
  logic [2:0]  ia_kind_r;
  logic [16:0] ia_amt_r;

  logic [CNT_BITS-1:0] quo1_r;
  logic [ANG_BITS-1:0] ang_b_r;
  logic [CNT_BITS-1:0] adj_r;

  logic                out_valid_r, out_valid_nxt;
  logic                o_cw_r, o_ccw_r, o_pwr_r, o_known_r, o_moving_r, o_done_r;
  logic [CNT_BITS-1:0] o_rel_r;
  logic [POS_BITS-1:0] o_abs_r;
  logic [2:0]          o_status_r;

  logic [POS_BITS-1:0] m;
  logic [2:0]          cmd_status;
  logic                move_go, need_short, need_adj, amt_neg, amt_pos;
  logic [POS_BITS-1:0] abs_tgt, short_tgt;
  logic                fire, div_start, div_done;
  logic [CNT_BITS-1:0] div_dividend, div_quotient, rel_mag;
  logic [CNT_BITS-1:0] qn1;
  logic [CNT_BITS+POS_BITS-1:0] prod;
  logic                done_flag, check_end, end_hit;
  drive_t              sel, short_sel;
  logic signed [ANG_BITS:0]   a1;
  logic [ANG_BITS:0]          mag, a2;
  logic signed [CNT_BITS+1:0] relx, stx, lim_hi, lim_lo;
  logic [CNT_BITS-1:0]        base;

  assign m       = (maxp_r == '0) ? POS_BITS'(1) : maxp_r;
  assign pready  = 1'b1;
  assign rel_mag = rel_r[CNT_BITS-1] ? (~rel_r + 1'b1) : rel_r;

  // command checks
  always_comb begin
    cmd_status = ST_OK;
    if (ia_dir_r == DIR_BAD) begin
      cmd_status = ST_NO_DIR;
    end else if (drv_r != DRV_STOP) begin
      cmd_status = ST_BUSY;
    end else if (!known_r && (ia_kind_r == KIND_ABS || ia_kind_r == KIND_TURN ||
                              ia_dir_r == DIR_SHORT)) begin
      cmd_status = ST_NOT_CAL;
    end else if (ia_dir_r == DIR_SHORT && (ia_kind_r == KIND_REL ||
                 ia_kind_r == KIND_TURN || ia_kind_r == KIND_MAN)) begin
      cmd_status = ST_NO_SHORT;
    end
    move_go = (ia_action_r == ACT_MOVE) && (cmd_status == ST_OK) && (ia_kind_r <= KIND_MAN);
    amt_neg = ia_amt_r[16];
    amt_pos = !ia_amt_r[16] && (ia_amt_r != '0);
    if (amt_neg) begin
      abs_tgt = '0;
    end else if (ia_amt_r[15:0] >= m) begin
      abs_tgt = m - 1'b1;
    end else begin
      abs_tgt = ia_amt_r[15:0];
    end
    short_tgt  = (ia_kind_r == KIND_HOME) ? '0 : abs_tgt;
    need_short = move_go && (ia_dir_r == DIR_SHORT) &&
                 (ia_kind_r == KIND_ABS || ia_kind_r == KIND_HOME);
    need_adj   = move_go && (ia_kind_r == KIND_REL) && cal_r &&
                 ((ia_dir_r == DIR_CW && amt_neg) || (ia_dir_r != DIR_CW && amt_pos));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = (need_adj || need_short) ? S_DIV1 : S_APPLY;
      S_DIV1:   if (div_done) state_nxt = need_short ? S_DIV2 : S_MUL;
      S_DIV2:   if (div_done) state_nxt = S_APPLY;
      S_MUL:    state_nxt = S_APPLY;
      S_APPLY:  if (fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = times_360(abs_r);
    fire         = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_DECIDE: begin
        div_start    = need_adj || need_short;
        div_dividend = need_adj ? rel_mag : times_360(short_tgt);
      end
      S_DIV1: div_start = div_done && need_short;
      S_DIV2, S_MUL: ;
      S_APPLY: fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  drpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (m),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign qn1  = (rel_r[CNT_BITS-1] ? (~quo1_r + 1'b1) : quo1_r) + 1'b1;
  assign prod = qn1 * m;

  // shortest direction from the two angles
  always_comb begin
    a1  = $signed({1'b0, quo1_r[ANG_BITS-1:0]}) - $signed({1'b0, ang_b_r});
    mag = a1[ANG_BITS] ? (~a1 + 1'b1) : a1;
    a2  = {1'b0, FULL_CIRCLE} - mag;
    if (mag < a2) begin
      short_sel = (a1 > 0) ? DRV_CW : DRV_CCW;
    end else begin
      short_sel = (a1 > 0) ? DRV_CCW : DRV_CW;
    end
  end

  // item update
  always_comb begin
    rel_n     = rel_r;
    abs_n     = abs_r;
    known_n   = known_r;
    prev_n    = prev_r;
    drv_n     = drv_r;
    kind_n    = kind_r;
    tgt_n     = tgt_r;
    wrap_n    = wrap_r;
    start_n   = start_r;
    pwr_n     = pwr_r;
    done_flag = 1'b0;
    check_end = 1'b0;
    end_hit   = 1'b0;
    sel       = (ia_dir_r == DIR_CW) ? DRV_CW : DRV_CCW;
    base      = rel_r + {{(CNT_BITS-17){ia_amt_r[16]}}, ia_amt_r};
    case (ia_action_r)
      ACT_TICK: begin
        if (drv_r == DRV_CW && prev_r && !ia_enc_r) begin
          rel_n = rel_r + 1'b1;
          if (known_r) begin
            abs_n = ({1'b0, abs_r} + 1'b1 >= {1'b0, m}) ? '0 : abs_r + 1'b1;
          end
        end else if (drv_r == DRV_CCW && !prev_r && ia_enc_r) begin
          rel_n = rel_r - 1'b1;
          if (known_r) begin
            abs_n = (abs_r == '0) ? m - 1'b1 : abs_r - 1'b1;
          end
        end
        prev_n    = ia_enc_r;
        pwr_n     = ia_home_r;
        check_end = 1'b1;
      end
      ACT_MOVE: begin
        if (move_go) begin
          start_n = rel_r;
          kind_n  = ia_kind_r;
          wrap_n  = 1'b0;
          case (ia_kind_r)
            KIND_REL: begin
              tgt_n = base;
              if (!cal_r) begin
                if (sel == DRV_CW && amt_neg) begin
                  sel = DRV_CCW;
                end else if (sel == DRV_CCW && amt_pos) begin
                  sel = DRV_CW;
                end
              end else if (need_adj) begin
                tgt_n = (sel == DRV_CW) ? base + adj_r : base - adj_r;
              end
            end
            KIND_ABS: begin
              tgt_n = {{(CNT_BITS-POS_BITS){1'b0}}, abs_tgt};
              if (ia_dir_r == DIR_SHORT) sel = short_sel;
              wrap_n = (sel == DRV_CW) ? !(abs_tgt > abs_r) : !(abs_tgt < abs_r);
            end
            KIND_HOME: begin
              tgt_n = '0;
              if (ia_dir_r == DIR_SHORT) sel = short_sel;
            end
            default: tgt_n = {{(CNT_BITS-POS_BITS){1'b0}}, abs_r};
          endcase
          drv_n     = sel;
          check_end = 1'b1;
        end
      end
      ACT_STOP: begin
        if (drv_r != DRV_STOP) begin
          drv_n     = DRV_STOP;
          done_flag = 1'b1;
        end
      end
      default: begin
        if (cal_r && ia_home_r) begin
          rel_n   = '0;
          abs_n   = '0;
          known_n = 1'b1;
        end
      end
    endcase

    relx   = {{2{rel_n[CNT_BITS-1]}}, rel_n};
    stx    = {{2{start_n[CNT_BITS-1]}}, start_n};
    lim_hi = stx + $signed({{(CNT_BITS+2-POS_BITS){1'b0}}, m});
    lim_lo = stx - $signed({{(CNT_BITS+2-POS_BITS){1'b0}}, m});
    if (check_end && drv_n != DRV_STOP) begin
      case (kind_n)
        KIND_REL: begin
          end_hit = (drv_n == DRV_CW) ? ($signed(rel_n) >= $signed(tgt_n))
                                      : ($signed(rel_n) <= $signed(tgt_n));
        end
        KIND_ABS: begin
          if (drv_n == DRV_CW) begin
            if (wrap_n && {{(CNT_BITS-POS_BITS){1'b0}}, abs_n} <= tgt_n) wrap_n = 1'b0;
            end_hit = !wrap_n && ({{(CNT_BITS-POS_BITS){1'b0}}, abs_n} >= tgt_n);
          end else begin
            if (wrap_n && {{(CNT_BITS-POS_BITS){1'b0}}, abs_n} >= tgt_n) wrap_n = 1'b0;
            end_hit = !wrap_n && ({{(CNT_BITS-POS_BITS){1'b0}}, abs_n} <= tgt_n);
          end
        end
        KIND_HOME: begin
          end_hit = ia_home_r || ((drv_n == DRV_CW) ? (relx >= lim_hi) : (relx <= lim_lo));
        end
        KIND_TURN: begin
          end_hit = (drv_n == DRV_CW) ? (relx >= lim_hi) : (relx <= lim_lo);
        end
        default: end_hit = 1'b0;
      endcase
      if (end_hit) begin
        drv_n     = DRV_STOP;
        done_flag = 1'b1;
      end
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      maxp_r      <= POS_BITS'(1);
      cal_r       <= 1'b0;
      rel_r       <= '0;
      abs_r       <= '0;
      known_r     <= 1'b0;
      prev_r      <= 1'b0;
      drv_r       <= DRV_STOP;
      kind_r      <= '0;
      tgt_r       <= '0;
      wrap_r      <= 1'b0;
      start_r     <= '0;
      pwr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite) begin
        case (paddr)
          ADDR_MAX_POS: maxp_r <= pwdata[POS_BITS-1:0];
          ADDR_CAL:     cal_r  <= pwdata[0];
          default: ;
        endcase
      end
      if (fire) begin
        rel_r   <= rel_n;
        abs_r   <= abs_n;
        known_r <= known_n;
        prev_r  <= prev_n;
        drv_r   <= drv_n;
        kind_r  <= kind_n;
        tgt_r   <= tgt_n;
        wrap_r  <= wrap_n;
        start_r <= start_n;
        pwr_r   <= pwr_n;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ia_action_r <= in_action;
      ia_enc_r    <= in_encoder_level;
      ia_home_r   <= in_home_sensor;
      ia_dir_r    <= in_direction;
      ia_kind_r   <= in_target_kind;
      ia_amt_r    <= in_amount;
    end
    if (state_r == S_DIV1 && div_done) quo1_r <= div_quotient;
    if (state_r == S_DIV2 && div_done) ang_b_r <= div_quotient[ANG_BITS-1:0];
    if (state_r == S_MUL) adj_r <= prod[CNT_BITS-1:0];
    if (fire) begin
      o_cw_r     <= (drv_n == DRV_CW);
      o_ccw_r    <= (drv_n == DRV_CCW);
      o_pwr_r    <= pwr_n;
      o_rel_r    <= rel_n;
      o_abs_r    <= known_n ? abs_n : '0;
      o_known_r  <= known_n;
      o_moving_r <= (drv_n != DRV_STOP);
      o_done_r   <= done_flag;
      o_status_r <= (ia_action_r == ACT_MOVE) ? cmd_status : ST_OK;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MAX_POS: prdata = {{(32-POS_BITS){1'b0}}, maxp_r};
      ADDR_CAL:     prdata = {31'b0, cal_r};
      default:      prdata = '0;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_cw_drive          = o_cw_r;
  assign out_ccw_drive         = o_ccw_r;
  assign out_power_on          = o_pwr_r;
  assign out_relative_position = o_rel_r;
  assign out_absolute_position = o_abs_r;
  assign out_absolute_valid    = o_known_r;
  assign out_moving            = o_moving_r;
  assign out_move_done         = o_done_r;
  assign out_command_status    = o_status_r;

endmodule

>>> rtl/core/drpc_checker.sv
`timescale 1ns / 1ps
module drpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_cw_drive,
  input logic                          out_ccw_drive,
  input logic [drpc_pkg::POS_BITS-1:0] out_absolute_position,
  input logic                          out_absolute_valid,
  input logic                          out_moving,
  input logic                          out_move_done
);
  import drpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_absolute_position))
    else $error("result dropped or changed under stall");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_cw_drive && out_ccw_drive) &&
                  (out_moving == (out_cw_drive || out_ccw_drive)))
    else $error("drive outputs inconsistent");

  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_moving)
    else $error("move done while still moving");

  a_abs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_absolute_valid |-> out_absolute_position == '0)
    else $error("absolute position shown while unknown");

endmodule

bind dome_rotation_position_controller drpc_checker u_drpc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_cw_drive          (out_cw_drive),
  .out_ccw_drive         (out_ccw_drive),
  .out_absolute_position (out_absolute_position),
  .out_absolute_valid    (out_absolute_valid),
  .out_moving            (out_moving),
  .out_move_done         (out_move_done)
);
